>>> rtl/roulette_wheel_selector_top_defines.svh
// Assertion macros for the roulette wheel selector checker.
`ifndef ROULETTE_WHEEL_SELECTOR_TOP_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_TOP_DEFINES_SVH

// Check a property on the rising clock, ignoring cycles held in reset.
`define RWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on the rising clock, reset cycles included.
`define RWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/rws_pkg.sv
// Types and constants shared by the roulette wheel selector modules.
`default_nettype none

package rws_pkg;

    // Width of the fitness total and running sum
    localparam int SUM_W        = 24;
    localparam int FIT_W        = 16;
    localparam int ROLL_W       = 16;
    localparam int SLOT_W       = 8;
    localparam int POP_SIZE_W   = 9;
    localparam logic [POP_SIZE_W-1:0] POP_SIZE_RST = 9'd256;

    // Request codes
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_PICK  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] slot;
        logic [FIT_W-1:0]  fitness;
        logic [ROLL_W-1:0] roll;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] chosen;
        logic              found;
    } t_out_item;

    // Memory port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

>>> rtl/rws_fit_mem.sv
// Fitness memory: one write port, one read port with registered data.
`default_nettype none

module rws_fit_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                          i_clk,
    input  rws_pkg::t_mem_ctl            i_ctl,
    input  wire  [AW-1:0]                i_wr_addr,
    input  wire  [rws_pkg::FIT_W-1:0]    i_wr_data,
    input  wire  [AW-1:0]                i_rd_addr,
    output logic [rws_pkg::FIT_W-1:0]    o_rd_data
);

    logic [rws_pkg::FIT_W-1:0] r_mem [DEPTH];

    // Write a stored fitness
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, updated only when rd_en is set
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/rws_ctrl.sv
// Selection sequencer: sums the fitness memory, then walks it against the roll.
`default_nettype none

module rws_ctrl #(
    parameter int MAX_POP   = 256,
    parameter int ROLL_BITS = 16,
    parameter int AW        = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [rws_pkg::POP_SIZE_W-1:0]     i_pop_size,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  rws_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output rws_pkg::t_out_item                 o_out_data,
    output rws_pkg::t_mem_ctl                  o_mem_ctl,
    output logic [AW-1:0]                      o_wr_addr,
    output logic [rws_pkg::FIT_W-1:0]          o_wr_data,
    output logic [AW-1:0]                      o_rd_addr,
    input  wire  [rws_pkg::FIT_W-1:0]          i_rd_data
);

    localparam int CW  = $clog2(MAX_POP + 1);
    localparam int PW  = rws_pkg::SUM_W + ROLL_BITS;
    localparam int RXW = (ROLL_BITS > rws_pkg::ROLL_W) ? ROLL_BITS : rws_pkg::ROLL_W;
    localparam int SW  = rws_pkg::SUM_W;

    rws_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_n, n_n;
    logic               r_rd_vld, n_rd_vld;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic [SW-1:0]      r_total, n_total;
    logic [SW-1:0]      r_run, n_run;
    logic [PW-1:0]      r_prod, n_prod;
    logic [ROLL_BITS-1:0] r_roll, n_roll;
    rws_pkg::t_out_item r_res, n_res;
    logic               r_out_valid, n_out_valid;
    rws_pkg::t_out_item r_out_data, n_out_data;

    logic [RXW-1:0]     roll_ext;
    logic [ROLL_BITS-1:0] roll_m;
    logic [CW-1:0]      eff_n;
    logic [AW+7:0]      slot_ext;
    logic [AW+7:0]      idx_ext;
    logic               slot_ok;
    logic [SW-1:0]      sum_next;
    logic               hit;
    logic               out_free;

    // Mask the roll and clamp the population size
    assign roll_ext = RXW'(i_in_data.roll);
    assign roll_m   = roll_ext[ROLL_BITS-1:0];
    assign eff_n    = (32'(i_pop_size) > MAX_POP) ? CW'(MAX_POP) : CW'(i_pop_size);
    assign slot_ext = (AW + 8)'(i_in_data.slot);
    assign slot_ok  = 32'(i_in_data.slot) < MAX_POP;
    assign idx_ext  = (AW + 8)'(r_rd_idx);

    // Accumulate and compare against roll * total
    assign sum_next = r_run + SW'(i_rd_data);
    assign hit      = {sum_next, {ROLL_BITS{1'b0}}} >= r_prod;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_wr_addr   = slot_ext[AW-1:0];
    assign o_wr_data   = i_in_data.fitness;
    assign o_rd_addr   = r_cnt[AW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_total     = r_total;
        n_run       = r_run;
        n_prod      = r_prod;
        n_roll      = r_roll;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_mem_ctl   = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            rws_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_data.req_type == rws_pkg::REQ_PICK) begin
                        n_roll  = roll_m;
                        n_n     = eff_n;
                        n_cnt   = '0;
                        n_total = '0;
                        n_state = rws_pkg::ST_SUM;
                    end else if (slot_ok) begin
                        o_mem_ctl.wr_en = 1'b1;
                    end
                end
            end
            rws_pkg::ST_SUM: begin
                if (r_rd_vld) begin
                    n_total = r_total + SW'(i_rd_data);
                end
                if (r_cnt != r_n) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_cnt           = r_cnt + 1'b1;
                    n_rd_vld        = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = rws_pkg::ST_MUL;
                end
            end
            rws_pkg::ST_MUL: begin
                n_prod = {{SW{1'b0}}, r_roll} * {{ROLL_BITS{1'b0}}, r_total};
                if (r_total == '0) begin
                    n_res   = '0;
                    n_state = rws_pkg::ST_FIN;
                end else begin
                    n_cnt   = '0;
                    n_run   = '0;
                    n_state = rws_pkg::ST_SCAN;
                end
            end
            rws_pkg::ST_SCAN: begin
                if (r_rd_vld && hit) begin
                    n_res.found  = 1'b1;
                    n_res.chosen = idx_ext[7:0];
                    n_state      = rws_pkg::ST_FIN;
                end else begin
                    if (r_rd_vld) begin
                        n_run = sum_next;
                    end
                    if (r_cnt != r_n) begin
                        o_mem_ctl.rd_en = 1'b1;
                        n_cnt           = r_cnt + 1'b1;
                        n_rd_vld        = 1'b1;
                        n_rd_idx        = r_cnt[AW-1:0];
                    end else if (!r_rd_vld) begin
                        n_res   = '0;
                        n_state = rws_pkg::ST_FIN;
                    end
                end
            end
            rws_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = rws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rws_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rws_pkg::ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_n        <= n_n;
        r_rd_idx   <= n_rd_idx;
        r_total    <= n_total;
        r_run      <= n_run;
        r_prod     <= n_prod;
        r_roll     <= n_roll;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

>>> rtl/roulette_wheel_selector_top.sv
// Top level of the fitness-proportionate roulette wheel selector.
//
//   channel | direction | beat carries
//   --------+-----------+------------------------------------------
//   in      | sink      | t_in_item: req_type, slot, fitness, roll
//   out     | source    | t_out_item: chosen, found (one per pick)
//   cfg     | sink      | pop_size, 9 bits
//
// A store is written straight to the fitness memory. A pick walks the clamped
// pop_size slots over the single read port of the fitness memory, once to
// sum and once to accumulate up to the hit, one slot per cycle each.
// Reset is synchronous, active low; it clears control state and sets pop_size
// to 256. No clearing pass: slots must be stored before a pick reads them.
// A finished result waits in the output register while the next item enters.
`default_nettype none

module roulette_wheel_selector_top #(
    parameter int MAX_POP   = 256,
    parameter int ROLL_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  rws_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output rws_pkg::t_out_item               o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [rws_pkg::POP_SIZE_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(MAX_POP);

    logic [rws_pkg::POP_SIZE_W-1:0] r_pop_size;
    rws_pkg::t_mem_ctl              mem_ctl;
    logic [AW-1:0]                  wr_addr;
    logic [rws_pkg::FIT_W-1:0]      wr_data;
    logic [AW-1:0]                  rd_addr;
    logic [rws_pkg::FIT_W-1:0]      rd_data;

    // Take configuration beats at any time
    assign o_cfg_ready = 1'b1;

    // Hold the population size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_size <= rws_pkg::POP_SIZE_RST;
        end else if (i_cfg_valid) begin
            r_pop_size <= i_cfg_data;
        end
    end

    rws_ctrl #(
        .MAX_POP   (MAX_POP),
        .ROLL_BITS (ROLL_BITS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_size  (r_pop_size),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    rws_fit_mem #(
        .DEPTH (MAX_POP),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> rtl/rws_checker.sv
// Port-level checker for the roulette wheel selector, bound to the top level.
`default_nettype none
`include "roulette_wheel_selector_top_defines.svh"

module rws_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_ready,
    input rws_pkg::t_in_item  i_in_data,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input rws_pkg::t_out_item o_out_data
);

    // Hold a stalled result beat
    `RWS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // Drop any pending result on reset
    `RWS_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // Report slot zero when nothing is found
    `RWS_ASSERT(a_nofind_zero, o_out_valid && !o_out_data.found |-> o_out_data.chosen == '0, "nonzero slot without a find")

    // Go busy after a pick beat
    `RWS_ASSERT(a_pick_busy, i_in_valid && o_in_ready && i_in_data.req_type == rws_pkg::REQ_PICK |=> !o_in_ready, "input ready right after a pick")

endmodule

bind roulette_wheel_selector_top rws_checker u_rws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
